### design/s256_pkg.sv
// package: constants, types and round functions for the sha-256 stream hasher
`default_nettype none
package s256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned QueueDepth = 2;

    typedef logic [31:0] t_word;

    // one packed block handed from the front part to the back part
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } t_job;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_msg;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } t_out_item;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [6:0] LenPos  = 7'd56;

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word ror(input t_word v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig1(input t_word x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sig0(input t_word a);
        return ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
    endfunction

    function automatic t_word big_sig1(input t_word e);
        return ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
    endfunction

endpackage
`default_nettype wire

### design/s256_stream_if.sv
// valid/ready stream interface used by the input and output channels
`default_nettype none
interface s256_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/s256_front.sv
// front part: packs bytes, counts length, pads the last block and queues blocks
`default_nettype none
module s256_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    s256_stream_if.sink               i_in,
    output      s256_pkg::t_job       o_job,
    output      logic                 o_job_valid,
    input  wire logic                 i_job_ready
);
    import s256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PAD  = 3'b010,
        ST_LEN  = 3'b100
    } t_state;

    t_state       r_state, n_state;
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_len, n_len;

    // two-entry block queue
    t_job        r_q [QueueDepth];
    logic [1:0]  r_qcnt;
    logic        r_qwr, r_qrd;
    logic        push, pop;
    t_job        push_job;
    logic        accept;

    assign pop         = o_job_valid && i_job_ready;
    assign o_job_valid = r_qcnt != 2'd0;
    assign o_job       = r_q[r_qrd];
    // room needed for a block that this cycle may produce
    assign i_in.ready  = (r_state == ST_IDLE) && (r_qcnt != 2'(QueueDepth));
    assign accept      = i_in.valid && i_in.ready;

    function automatic logic [511:0] put_byte(input logic [511:0] b, input logic [5:0] p,
                                              input logic [7:0] v);
        logic [511:0] r;
        r = b;
        r[10'(511 - 8 * p) -: 8] = v;
        return r;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_blk    = r_blk;
        n_fill   = r_fill;
        n_len    = r_len;
        push     = 1'b0;
        push_job = '{block: r_blk, last: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.payload.byte_valid) begin
                        n_blk  = put_byte(r_blk, r_fill, i_in.payload.msg_byte);
                        n_len  = r_len + 61'd1;
                        n_fill = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            push     = 1'b1;
                            push_job = '{block: n_blk, last: 1'b0};
                        end
                    end
                    if (i_in.payload.end_of_msg) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                // room is guaranteed only after a possible full-block push drained
                if (r_qcnt != 2'(QueueDepth)) begin
                    n_blk = put_byte(r_blk, r_fill, PadByte);
                    for (int i = 0; i < BlockBytes; i++) begin
                        if (6'(i) > r_fill) n_blk[511 - 8 * i -: 8] = 8'h00;
                    end
                    if ({1'b0, r_fill} + 7'd1 > LenPos) begin
                        push     = 1'b1;
                        push_job = '{block: n_blk, last: 1'b0};
                        n_blk    = '0;
                    end
                    n_fill  = '0;
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (r_qcnt != 2'(QueueDepth)) begin
                    push     = 1'b1;
                    push_job = '{block: {r_blk[511:64], r_len, 3'b000}, last: 1'b1};
                    n_len    = '0;
                    n_fill   = '0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            r_qcnt  <= '0;
            r_qwr   <= 1'b0;
            r_qrd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_len   <= n_len;
            if (push) r_qwr <= ~r_qwr;
            if (pop)  r_qrd <= ~r_qrd;
            r_qcnt <= r_qcnt + {1'b0, push} - {1'b0, pop};
        end
        r_blk <= n_blk;
        if (push) r_q[r_qwr] <= push_job;
    end
endmodule
`default_nettype wire

### design/s256_back.sv
// back part: 64-round compression, one round per cycle, and digest output
`default_nettype none
module s256_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire s256_pkg::t_job i_job,
    input  wire logic           i_job_valid,
    output      logic           o_job_ready,
    s256_stream_if.source       o_out
);
    import s256_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state       r_state;
    logic [255:0] r_h;
    logic [255:0] r_v;
    logic [511:0] r_w;      // sliding window of 16 schedule words, w[t] on top
    logic [5:0]   r_rnd;
    logic         r_last;
    logic [2:0]   r_word;

    t_word a, b, c, d, e, f, g, h, wt, t1, t2, wnew;
    logic [255:0] sum_h;

    assign {a, b, c, d, e, f, g, h} = r_v;
    assign wt   = r_w[511 -: 32];
    assign t1   = h + big_sig1(e) + ((e & f) ^ (~e & g)) + round_k(r_rnd) + wt;
    assign t2   = big_sig0(a) + ((a & b) ^ (a & c) ^ (b & c));
    assign wnew = r_w[511 -: 32] + sig0(r_w[479 -: 32]) + r_w[223 -: 32] + sig1(r_w[63 -: 32]);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum_h[32 * i +: 32] = r_h[32 * i +: 32] + r_v[32 * i +: 32];
        end
    end

    assign o_job_ready   = r_state == ST_IDLE;
    assign o_out.valid   = r_state == ST_EMIT;
    assign o_out.payload = '{digest_word: r_h[255 - 32 * r_word -: 32],
                             word_number: r_word,
                             final_word:  r_word == 3'd7};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h     <= InitHash;
            r_word  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_job_valid) r_state <= ST_ROUND;
                ST_ROUND: if (r_rnd == 6'(Rounds - 1)) r_state <= ST_ADD;
                ST_ADD: begin
                    r_h     <= sum_h;
                    r_state <= r_last ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (o_out.ready) begin
                        r_word <= r_word + 3'd1;
                        if (r_word == 3'd7) begin
                            r_h     <= InitHash;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        if (r_state == ST_IDLE) begin
            r_v    <= r_h;
            r_w    <= i_job.block;
            r_last <= i_job.last;
            r_rnd  <= '0;
        end else if (r_state == ST_ROUND) begin
            r_v   <= {t1 + t2, a, b, c, d + t1, e, f, g};
            r_w   <= {r_w[479:0], wnew};
            r_rnd <= r_rnd + 6'd1;
        end
    end
endmodule
`default_nettype wire

### design/sha256_stream_hasher_top.sv
// top level of the sha-256 stream hasher
//
// input channel: items of msg_byte, byte_valid and end_of_msg, one per cycle while ready.
// an item with end_of_msg closes the message; the block pads it and then
// delivers eight digest words on the output channel, word 0 first, the last
// one flagged with final_word.
// the front packs bytes into a 64-byte block and hands full blocks through a
// two-block queue to the back, which runs one compression round per cycle:
// each block is loaded, runs 64 rounds and then the chaining add.
// bytes are taken at one per cycle while the queue has room and no padding runs;
// sustained throughput is set by the round unit, which takes one block at a time.
// after end_of_msg the front pads in ST_PAD and then ST_LEN; the first digest
// word is valid once the last block has run its rounds and the chaining add.
// reset is synchronous, active low, and brings back the initial hash values
// with an empty block and zero length.
// a stalled output holds the current digest word; the front keeps taking bytes
// of the next message until the queue fills.
`default_nettype none
module sha256_stream_hasher_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    s256_stream_if.sink   i_in,
    s256_stream_if.source o_out
);
    import s256_pkg::*;

    t_job job;
    logic job_valid;
    logic job_ready;

    s256_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready)
    );

    s256_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

### bench/sha256_digest_checker.sv
// checker: predicts sha-256 digests from accepted items and compares output words
`timescale 1ns / 100ps
`default_nettype none
module sha256_digest_checker
    import s256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire t_in_item    i_in_item,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out_item   i_out_item,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);

    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] msg_len;
    t_out_item   expected_words [$];

    function automatic logic [31:0] rr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) chain[i] = InitHash[255 - 32*i -: 32];
        fill = 0;
        msg_len = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (rr(x, 7) ^ rr(x, 18) ^ (x >> 3)) + w[i-7]
                 + (rr(y, 17) ^ rr(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic take_item(input t_in_item it);
        logic [63:0] bits;
        t_out_item   o;
        if (it.byte_valid) begin
            blk[fill] = it.msg_byte;
            fill++;
            msg_len++;
            if (fill == 64) begin
                compress_block();
                fill = 0;
            end
        end
        if (it.end_of_msg) begin
            bits = {msg_len, 3'b000};
            blk[fill++] = PadByte;
            if (fill > LenPos) begin
                while (fill < 64) blk[fill++] = 8'h00;
                compress_block();
                fill = 0;
            end
            while (fill < LenPos) blk[fill++] = 8'h00;
            for (int i = 0; i < 8; i++) blk[63 - i] = bits[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = chain[i];
                o.word_number = 3'(i);
                o.final_word  = (i == 7);
                expected_words.push_back(o);
            end
            restart_hash();
        end
    endtask

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            o_fail_count = 0;
            expected_words.delete();
            restart_hash();
        end else begin
            if (i_in_valid && i_in_ready) take_item(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected digest word %h", i_out_item);
                end else begin
                    e = expected_words.pop_front();
                    if (e.digest_word !== i_out_item.digest_word ||
                        e.word_number !== i_out_item.word_number ||
                        e.final_word !== i_out_item.final_word) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                e.digest_word, e.word_number, e.final_word,
                                i_out_item.digest_word, i_out_item.word_number,
                                i_out_item.final_word);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

### bench/tb_sha256_stream_hasher_top.sv
// testbench top: byte stream stimulus, output stalls and the verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_stream_hasher_top;
    import s256_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    logic        stall_mode = 1'b0;

    s256_stream_if #(.t_payload(t_in_item))  in_ch ();
    s256_stream_if #(.t_payload(t_out_item)) out_ch ();

    sha256_stream_hasher_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sha256_digest_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_item    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_item   (out_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
    end

    // receiver: alternates free-running stretches and random stalls
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        if (!stall_mode) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 3) != 0);
        if (cycle_count > 600000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    int unsigned burst_left = 0;

    // sends one item; random gaps come between bursts, valid stays up within a burst
    task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
        t_in_item it;
        int unsigned gap;
        it.msg_byte   = b;
        it.byte_valid = bv;
        it.end_of_msg = eom;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_message(input int unsigned len, input logic rand_noise);
        for (int unsigned i = 0; i < len; i++) begin
            if (rand_noise && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            if (i + 1 == len && $urandom_range(0, 1) == 0) begin
                send_item(8'($urandom), 1'b1, 1'b1);
                return;
            end
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned waited;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ignored byte, empty message, then all-ones, all-zero and 5a bytes
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5a, 1'b1, 1'b1);
        // sixteen-byte message closed by an end without a byte
        for (int i = 0; i < 16; i++) send_item(8'(i * 17), 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);

        // hold off until all digests drain
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        sent = 0;
        while (sent < 250) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 58);
                2: len = $urandom_range(62, 66);
                3: len = $urandom_range(118, 130);
                default: len = $urandom_range(1, 40);
            endcase
            send_message(len, 1'b1);
            sent += len + 1;
        end
        in_ch.valid <= 1'b0;

        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 20000);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
design/s256_pkg.sv
design/s256_stream_if.sv
design/s256_front.sv
design/s256_back.sv
design/sha256_stream_hasher_top.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_stream_hasher_top.sv
